FILE: rtl/core/ast_pkg.sv
// Shared types and constants for the array-backed set table.
// Used by ast_ctrl, array_set_table and the testbench; depends on nothing.
package ast_pkg;

  localparam int DEPTH = 64;
  localparam int KEY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 7;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int OUT_W = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOCHG = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              found;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
    logic              full_res;
  } result_t;

endpackage

FILE: rtl/core/ast_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the key table; no dependencies.
module ast_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int WORDS = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ast_ctrl.sv
// Sequencer for the set table: linear search with one shared key compare,
// then insert append or remove swap-with-last. Depends on ast_pkg.
module ast_ctrl import ast_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  key,
  input  logic [CNT_W-1:0]  lim,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  output ram_wr_t           ram_wr,
  output logic [IDX_W-1:0]  ram_raddr,
  input  logic [KEY_W-1:0]  ram_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SWAP   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic              match;
  logic              issue;
  logic [CNT_W-1:0]  last;

  assign match = pend_r && (ram_rdata == key_r);
  assign issue = (scan_r != count_r);
  assign last  = count_r - CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    key_nxt      = key_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    found_nxt    = found_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    ram_wr.we    = 1'b0;
    ram_wr.addr  = count_r[IDX_W-1:0];
    ram_wr.data  = key_r;
    ram_raddr    = scan_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = func;
          key_nxt   = key;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Issue one read per cycle; compare the word read last cycle.
        if (issue) begin
          scan_nxt     = scan_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (match) begin
          found_nxt = 1'b1;
          slot_nxt  = pend_idx_r;
          pend_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end else if (!issue) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        status_nxt = ST_DONE;
        state_nxt  = S_DONE;
        case (func_r)
          FUNC_INSERT: begin
            if (found_r) begin
              status_nxt = ST_NOCHG;
            end else if (count_r >= lim) begin
              status_nxt = ST_FULL;
            end else begin
              ram_wr.we = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          FUNC_REMOVE: begin
            if (!found_r) begin
              status_nxt = ST_NOCHG;
            end else begin
              count_nxt = last;
              // Fetch the last entry to fill the hole unless the hole is last.
              if (slot_r != last[IDX_W-1:0]) begin
                ram_raddr = last[IDX_W-1:0];
                state_nxt = S_SWAP;
              end
            end
          end
          default: begin
            status_nxt = ST_DONE;
          end
        endcase
      end
      S_SWAP: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = slot_r;
        ram_wr.data = ram_rdata;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    scan_r     <= scan_nxt;
    pend_idx_r <= pend_idx_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.found     = found_r;
  assign res.status    = status_r;
  assign res.count     = count_r;
  assign res.empty_res = (count_r == '0);
  assign res.full_res  = (count_r >= lim);

endmodule

FILE: rtl/core/array_set_table.sv
// Set of distinct keys in a packed table, linear search; uses ast_pkg, ast_ram, ast_ctrl.
// A request is searched slot by slot until a hit or the end of the count, then decided;
// a remove that moves the last entry into the hole adds a swap step.
// One item at a time: a new request is taken only once the last result is in the output
// register; the search is bound by the single RAM read port and compare; out_tready stalls add delay.
// Reset (synchronous, rst_n low): count cleared, capacity_limit 64, table not cleared.
module array_set_table import ast_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [KEY_W-1:0]  in_tdata,    // [31:0] key
  input  logic [FUNC_W-1:0] in_tuser,    // [1:0] func
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] found, [2:1] status, [9:3] count, [10] empty_res, [11] full_res,
  // [15:12] zero
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data
);

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] lim;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  ram_wr_t          ram_wr;
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic             out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Clamp the limit to the table depth
  assign lim = (CNT_W'(cap_r) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);

  ast_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .func      (in_tuser),
    .key       (in_tdata),
    .lim       (lim),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ast_ram #(
    .DATA_W (KEY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    if (res_valid && res_ready) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = {4'b0000, res.full_res, res.empty_res, res.count, res.status,
                      res.found};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: tb/tb_array_set_table.sv
// Self-checking testbench for array_set_table: lookup, insert and remove beats against
// a predicted copy of the key table, with random input gaps and random output back-pressure.
// Depends on ast_pkg and the array_set_table RTL.
`timescale 1ns / 1ps

module tb_array_set_table import ast_pkg::*; ();

  // func code the block does not define; it must behave as a lookup
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int POOL_N = 80;

  class set_scoreboard;
    logic [KEY_W-1:0] keys [DEPTH];
    int unsigned held;
    logic [CAP_W-1:0] limit;
    result_t due [$];
    int errors;

    function new();
      held = 0;
      limit = CAP_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [CAP_W-1:0] value);
      limit = value;
    endfunction

    // Apply one accepted request to the shadow table and queue its result.
    function void note_request(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] key);
      int unsigned lim;
      int unsigned slot;
      bit hit;
      result_t r;
      lim = (limit > DEPTH) ? DEPTH : limit;
      slot = DEPTH;
      for (int i = 0; i < held; i++) begin
        if (slot == DEPTH && keys[i] == key) slot = i;
      end
      hit = (slot < DEPTH);
      r.status = ST_DONE;
      if (op == FUNC_INSERT) begin
        if (hit) r.status = ST_NOCHG;
        else if (held >= lim) r.status = ST_FULL;
        else begin
          keys[held] = key;
          held++;
        end
      end else if (op == FUNC_REMOVE) begin
        if (!hit) r.status = ST_NOCHG;
        else begin
          // move the last entry into the freed slot
          held--;
          keys[slot] = keys[held];
        end
      end
      r.found = hit;
      r.count = CNT_W'(held);
      r.empty_res = (held == 0);
      r.full_res = (held >= lim);
      due.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      result_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual %0h", $time, beat);
      end else begin
        want = due.pop_front();
        report("found", want.found, beat[0]);
        report("status", want.status, beat[2:1]);
        report("count", want.count, beat[9:3]);
        report("empty_res", want.empty_res, beat[10]);
        report("full_res", want.full_res, beat[11]);
        report("pad", 0, beat[OUT_W-1:12]);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [KEY_W-1:0]  in_tdata;    // [31:0] key
  logic [FUNC_W-1:0] in_tuser;    // [1:0] func
  logic              out_tvalid;
  logic              out_tready;
  // [0] found, [2:1] status, [9:3] count, [10] empty_res, [11] full_res, [15:12] zero
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;

  set_scoreboard sb;
  bit quiet;
  int gap_pct;
  int stall_pct;
  logic [KEY_W-1:0] pool [POOL_N];

  array_set_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: accept beats, stall in random bursts unless quiet.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 11);
      end
    end
  end

  task automatic send_request(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] key);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, key);
  endtask

  // Hold the input idle until every queued result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [CAP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_limit(value);
  endtask

  initial begin
    logic [FUNC_W-1:0] op;
    logic [KEY_W-1:0] key;
    int span;
    int pick;
    bit grow;

    sb = new();
    quiet = 1'b0;
    gap_pct = 20;
    stall_pct = 20;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= FUNC_LOOKUP;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extreme keys, duplicates, spare code, absent remove
    send_request(FUNC_LOOKUP, 32'h0000_0000);
    send_request(FUNC_REMOVE, 32'h0000_0005);
    send_request(FUNC_INSERT, 32'h8000_0000);
    send_request(FUNC_INSERT, 32'h7FFF_FFFF);
    send_request(FUNC_INSERT, 32'h0000_0000);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'h8000_0000);
    send_request(FUNC_LOOKUP, 32'h7FFF_FFFF);
    send_request(FUNC_SPARE, 32'h0000_0000);
    send_request(FUNC_REMOVE, 32'h8000_0000);
    send_request(FUNC_LOOKUP, 32'hFFFF_FFFF);
    send_request(FUNC_REMOVE, 32'h0001_2345);
    // fill to a small limit, then full reject and full duplicate
    drain();
    write_limit(7'd4);
    send_request(FUNC_INSERT, 32'h5555_5555);
    send_request(FUNC_INSERT, 32'hAAAA_AAAA);
    send_request(FUNC_INSERT, 32'h0000_0000);
    // limit lowered below the count
    drain();
    write_limit(7'd2);
    send_request(FUNC_INSERT, 32'h0000_0001);
    send_request(FUNC_REMOVE, 32'h0000_0000);
    // zero limit: every insert rejected, removes still work
    drain();
    write_limit(7'd0);
    send_request(FUNC_INSERT, 32'h0000_0002);
    send_request(FUNC_REMOVE, 32'hFFFF_FFFF);
    send_request(FUNC_REMOVE, 32'h7FFF_FFFF);
    send_request(FUNC_REMOVE, 32'h5555_5555);
    // limit above depth acts as depth
    drain();
    write_limit(7'd127);
    send_request(FUNC_INSERT, 32'h0000_0009);
    send_request(FUNC_REMOVE, 32'h0000_0009);

    for (int i = 0; i < POOL_N; i++) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'hFFFF_FFFF;
    pool[3] = 32'h0000_0000;

    for (int ph = 0; ph < 14; ph++) begin
      drain();
      case (ph % 7)
        0: write_limit(7'd64);
        1: write_limit(7'd1);
        2: write_limit(7'($urandom_range(2, 8)));
        3: write_limit(7'd127);
        4: write_limit(7'($urandom_range(9, 63)));
        5: write_limit(7'd0);
        default: write_limit(7'd65);
      endcase
      quiet = (ph >= 12);
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 5;
        2: gap_pct = 15;
        default: gap_pct = 35;
      endcase
      stall_pct = 5 * $urandom_range(0, 6);
      for (int i = 0; i < 10; i++) pool[$urandom_range(4, POOL_N - 1)] = $urandom;
      case ($urandom_range(0, 2))
        0: span = 6;
        1: span = 24;
        default: span = POOL_N;
      endcase
      grow = (ph % 2 == 0);
      repeat (120) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) op = FUNC_SPARE;
        else if (pick < 22) op = FUNC_LOOKUP;
        else if (pick < (grow ? 75 : 50)) op = FUNC_INSERT;
        else op = FUNC_REMOVE;
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = pool[$urandom_range(0, span - 1)];
        send_request(op, key);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ast_pkg.sv
rtl/core/ast_ram.sv
rtl/core/ast_ctrl.sv
rtl/core/array_set_table.sv
tb/tb_array_set_table.sv
